### src/spms_pkg.sv
// Shared types, constants and exp tables for the set-pooled MLP softmax core.
// No dependencies; imported by the core only.
package spms_pkg;

    localparam int STONE_FEATURES_DEF  = 6;
    localparam int GLOBAL_FEATURES_DEF = 10;
    localparam int CLASSES_DEF         = 16;
    localparam int MAX_WIDTH_DEF       = 64;
    localparam int WEIGHT_WORDS_DEF    = 32768;

    localparam int CFG_AW    = 2;
    localparam int CFG_DW    = 7;
    localparam int CFG_RESET = 64;

    // Numerator width for e*65536 + tot/2 with up to 64 classes.
    localparam int DIV_NW = 34;

    typedef enum logic [1:0] {
        MODE_WEIGHT = 2'd0,
        MODE_STONE  = 2'd1,
        MODE_GLOBAL = 2'd2,
        MODE_NONE   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        CFG_STONE_HIDDEN = 2'd0,
        CFG_POOL         = 2'd1,
        CFG_HEAD_HIDDEN  = 2'd2,
        CFG_HEAD_SECOND  = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        L_PHI1,
        L_PHI2,
        L_HEAD1,
        L_HEAD2,
        L_OUT
    } t_layer;

    typedef enum logic [1:0] {
        X_MEM,
        X_REG,
        X_SUM,
        X_MAX
    } t_xsel;

    typedef enum logic [4:0] {
        S_IDLE,
        S_SETUP,
        S_BMOD,
        S_BREAD,
        S_BIAS,
        S_MAC,
        S_WB,
        S_POOL,
        S_MAXRD,
        S_MAX,
        S_EXRD,
        S_E1,
        S_E2,
        S_E3,
        S_EWR,
        S_DIVRD,
        S_DIVGO,
        S_DIVWAIT,
        S_OUT
    } t_state;

    function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
        if (v > 38'sd2147483647) return 32'sh7FFFFFFF;
        if (v < -38'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic [16:0] exp_int(input logic [3:0] k);
        case (k)
            4'd0:    return 17'd65536;
            4'd1:    return 17'd24109;
            4'd2:    return 17'd8869;
            4'd3:    return 17'd3263;
            4'd4:    return 17'd1200;
            4'd5:    return 17'd442;
            4'd6:    return 17'd162;
            4'd7:    return 17'd60;
            4'd8:    return 17'd22;
            4'd9:    return 17'd8;
            4'd10:   return 17'd3;
            4'd11:   return 17'd1;
            default: return 17'd0;
        endcase
    endfunction

    function automatic logic [16:0] exp_sixteenth(input logic [3:0] k);
        case (k)
            4'd0:    return 17'd65536;
            4'd1:    return 17'd61565;
            4'd2:    return 17'd57835;
            4'd3:    return 17'd54331;
            4'd4:    return 17'd51039;
            4'd5:    return 17'd47947;
            4'd6:    return 17'd45042;
            4'd7:    return 17'd42313;
            4'd8:    return 17'd39750;
            4'd9:    return 17'd37341;
            4'd10:   return 17'd35079;
            4'd11:   return 17'd32953;
            4'd12:   return 17'd30957;
            4'd13:   return 17'd29081;
            4'd14:   return 17'd27319;
            default: return 17'd25664;
        endcase
    endfunction

    function automatic logic [16:0] exp_256th(input logic [3:0] k);
        case (k)
            4'd0:    return 17'd65536;
            4'd1:    return 17'd65280;
            4'd2:    return 17'd65026;
            4'd3:    return 17'd64772;
            4'd4:    return 17'd64520;
            4'd5:    return 17'd64268;
            4'd6:    return 17'd64018;
            4'd7:    return 17'd63768;
            4'd8:    return 17'd63520;
            4'd9:    return 17'd63272;
            4'd10:   return 17'd63025;
            4'd11:   return 17'd62780;
            4'd12:   return 17'd62535;
            4'd13:   return 17'd62291;
            4'd14:   return 17'd62048;
            default: return 17'd61806;
        endcase
    endfunction

endpackage

### src/spms_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Standalone; used by the core for the softmax normalization.
module spms_div #(
    parameter int NW = 34,
    parameter int DW = 23
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [NW-1:0] o_quot
);
    localparam int CW = $clog2(NW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [DW:0]   r_rem;
    logic [NW-1:0] r_q;
    logic [DW-1:0] r_den;

    logic [DW:0] c_sh;
    logic        c_ge;
    logic [DW:0] c_rem;

    always_comb begin
        c_sh  = {r_rem[DW-1:0], r_q[NW-1]};
        c_ge  = c_sh >= {1'b0, r_den};
        c_rem = c_ge ? (c_sh - {1'b0, r_den}) : c_sh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
                r_rem  <= '0;
                r_q    <= i_num;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_rem <= c_rem;
                r_q   <= {r_q[NW-2:0], c_ge};
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

### src/set_pooled_mlp_softmax_inference_core.sv
// Set-pooled MLP classifier core: weight memory, scratch and pool memories, MAC sequencer.
// Depends on spms_pkg and spms_div.
// A weight write or plain feature element is taken in S_IDLE. A closing stone element
// runs the stone layers, bound by the single weight memory port (one term
// per cycle through a 3-deep MAC pipe). A closing global element runs the head layers,
// then the softmax, with a divider pass per class before each class transfer.
// Reset clears the pool valid flags and controls and sets the widths to 64.
module set_pooled_mlp_softmax_inference_core #(
    parameter int STONE_FEATURES  = spms_pkg::STONE_FEATURES_DEF,
    parameter int GLOBAL_FEATURES = spms_pkg::GLOBAL_FEATURES_DEF,
    parameter int CLASSES         = spms_pkg::CLASSES_DEF,
    parameter int MAX_WIDTH       = spms_pkg::MAX_WIDTH_DEF,
    parameter int WEIGHT_WORDS    = spms_pkg::WEIGHT_WORDS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [1:0]                  i_mode,
    input  logic [14:0]                 i_index,
    input  logic signed [15:0]          i_value,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [5:0]                  o_class_index,
    output logic [15:0]                 o_probability,
    output logic                        o_last_class,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [spms_pkg::CFG_AW-1:0] i_cfg_index,
    input  logic [spms_pkg::CFG_DW-1:0] i_cfg_data
);
    import spms_pkg::*;

    localparam int WAW  = $clog2(WEIGHT_WORDS);
    localparam int CW   = $clog2(MAX_WIDTH + 1);
    localparam int NMAX = (MAX_WIDTH > CLASSES) ? MAX_WIDTH : CLASSES;
    localparam int OW   = $clog2(NMAX + 1);
    localparam int HIN  = 2 * MAX_WIDTH + GLOBAL_FEATURES;
    localparam int IW   = $clog2(HIN + 1);
    localparam int BW   = WAW + OW + IW + 1;
    localparam int SD   = 2 * MAX_WIDTH + CLASSES;
    localparam int SAW  = $clog2(SD);
    localparam int PAW  = $clog2(MAX_WIDTH);
    localparam int SIW  = (STONE_FEATURES > 1) ? $clog2(STONE_FEATURES) : 1;
    localparam int GIW  = (GLOBAL_FEATURES > 1) ? $clog2(GLOBAL_FEATURES) : 1;
    localparam int TW   = $clog2(CLASSES * 65536 + 1);

    // Control state.
    t_state              r_state, n_state;
    t_layer              r_layer;
    logic                r_head;
    logic                r_seen;
    logic [CFG_DW-1:0]   r_sh, r_pw, r_hh, r_hs;
    logic                r_v1, r_v2;
    logic [MAX_WIDTH-1:0] r_pvld;

    // Datapath.
    logic [WAW-1:0]      r_base;
    logic [BW-1:0]       r_bptr;
    logic [WAW-1:0]      r_wptr;
    logic [OW-1:0]       r_o;
    logic [IW-1:0]       r_i;
    logic signed [31:0]  r_acc;
    logic signed [47:0]  r_prod;
    t_xsel               r_xsel;
    logic signed [31:0]  r_xreg;
    logic signed [31:0]  r_y;
    logic signed [31:0]  r_m;
    logic                r_big;
    logic [7:0]          r_dl;
    logic [16:0]         r_e;
    logic [TW-1:0]       r_tot;
    logic [5:0]          r_ocls;
    logic [15:0]         r_oprob;
    logic                r_olast;

    logic signed [15:0]  r_sbuf [STONE_FEATURES];
    logic signed [15:0]  r_gbuf [GLOBAL_FEATURES];

    // Memories.
    logic signed [15:0]  r_wmem [WEIGHT_WORDS];
    logic signed [15:0]  r_wq;
    logic signed [31:0]  r_smem [SD];
    logic signed [31:0]  r_sq;
    logic [63:0]         r_pmem [MAX_WIDTH];
    logic [63:0]         r_pq;
    logic                r_pvq;

    // Combinational.
    logic [CW-1:0]       c_sh, c_pw, c_hh, c_hs;
    logic [OW-1:0]       c_nout;
    logic [IW-1:0]       c_nin;
    logic                c_comp, c_relu;
    t_layer              c_next_layer;
    logic                c_issue, c_mac_done;
    logic                c_row_last, c_adv;
    logic [BW-1:0]       c_bsum;
    logic [WAW-1:0]      c_bend;
    logic [BW-1:0]       c_binc;
    logic [WAW-1:0]      c_winc;
    t_xsel               c_xsel;
    logic signed [31:0]  c_xreg;
    logic signed [31:0]  c_x;
    logic signed [31:0]  c_y;
    logic signed [31:0]  c_osum, c_omax;
    logic signed [31:0]  c_z;
    logic signed [32:0]  c_d;
    logic [34:0]         c_emul;
    logic [16:0]         c_etab;
    logic [16:0]         c_e;
    logic                c_klast;
    logic                c_wwe;
    logic [WAW-1:0]      c_wraddr;
    logic                c_swe;
    logic [SAW-1:0]      c_swaddr, c_sraddr;
    logic signed [31:0]  c_swdata;
    logic                c_pwe;
    logic [PAW-1:0]      c_praddr;
    logic                c_div_start;
    logic [DIV_NW-1:0]   c_div_num;
    logic                c_div_done;
    logic [DIV_NW-1:0]   c_div_q;

    function automatic logic [CW-1:0] clampw(input logic [CFG_DW-1:0] v);
        if (v == '0) return CW'(1);
        if (32'(v) > MAX_WIDTH) return CW'(MAX_WIDTH);
        return CW'(v);
    endfunction

    always_comb begin
        c_sh = clampw(r_sh);
        c_pw = clampw(r_pw);
        c_hh = clampw(r_hh);
        c_hs = clampw(r_hs);
        case (r_layer)
            L_PHI1: begin
                c_nout       = OW'(c_sh);
                c_nin        = IW'(STONE_FEATURES);
                c_next_layer = L_PHI2;
            end
            L_PHI2: begin
                c_nout       = OW'(c_pw);
                c_nin        = IW'(c_sh);
                c_next_layer = L_HEAD1;
            end
            L_HEAD1: begin
                c_nout       = OW'(c_hh);
                c_nin        = IW'(c_pw) + IW'(c_pw) + IW'(GLOBAL_FEATURES);
                c_next_layer = L_HEAD2;
            end
            L_HEAD2: begin
                c_nout       = OW'(c_hs);
                c_nin        = IW'(c_hh);
                c_next_layer = L_OUT;
            end
            default: begin
                c_nout       = OW'(CLASSES);
                c_nin        = IW'(c_hs);
                c_next_layer = L_OUT;
            end
        endcase
        c_comp = r_head ? (r_layer != L_PHI1 && r_layer != L_PHI2) : 1'b1;
        c_relu = r_layer != L_OUT;
    end

    // Address arithmetic; all weight addresses stay reduced below WEIGHT_WORDS.
    always_comb begin
        c_bsum     = r_bptr + BW'(c_nout);
        c_bend     = (c_bsum >= BW'(WEIGHT_WORDS)) ? WAW'(c_bsum - BW'(WEIGHT_WORDS))
                                                   : WAW'(c_bsum);
        c_binc     = (r_bptr + BW'(1) == BW'(WEIGHT_WORDS)) ? '0 : r_bptr + BW'(1);
        c_winc     = (r_wptr == WAW'(WEIGHT_WORDS - 1)) ? '0 : r_wptr + WAW'(1);
        c_row_last = (r_o + OW'(1)) == c_nout;
        c_issue    = (r_state == S_MAC) && (r_i < c_nin);
        c_mac_done = !c_issue && !r_v1 && !r_v2;
        c_adv      = (r_state == S_WB && r_layer != L_PHI2) || (r_state == S_POOL);
        c_klast    = (r_o == OW'(CLASSES - 1));
    end

    // Operand fetch for one MAC term.
    always_comb begin
        c_xsel   = X_MEM;
        c_xreg   = '0;
        c_sraddr = SAW'(2 * MAX_WIDTH) + SAW'(r_o);
        c_praddr = PAW'(r_o);
        if (r_state == S_MAC) begin
            case (r_layer)
                L_PHI1: begin
                    c_xsel = X_REG;
                    c_xreg = 32'(r_sbuf[SIW'(r_i)]);
                end
                L_HEAD1: begin
                    if (r_i < IW'(c_pw)) begin
                        c_xsel   = X_SUM;
                        c_praddr = PAW'(r_i);
                    end else if (r_i < IW'(c_pw) + IW'(c_pw)) begin
                        c_xsel   = X_MAX;
                        c_praddr = PAW'(r_i - IW'(c_pw));
                    end else begin
                        c_xsel = X_REG;
                        c_xreg = 32'(r_gbuf[GIW'(r_i - IW'(c_pw) - IW'(c_pw))]);
                    end
                end
                L_OUT:   c_sraddr = SAW'(MAX_WIDTH) + SAW'(r_i);
                default: c_sraddr = SAW'(r_i);
            endcase
        end
    end

    always_comb begin
        case (r_xsel)
            X_MEM:   c_x = r_sq;
            X_REG:   c_x = r_xreg;
            X_SUM:   c_x = r_pvq ? $signed(r_pq[63:32]) : 32'sd0;
            default: c_x = !r_seen ? 32'sd0 : (r_pvq ? $signed(r_pq[31:0]) : 32'sh80000000);
        endcase
        c_y    = (c_relu && r_acc < 0) ? 32'sd0 : r_acc;
        c_osum = r_pvq ? $signed(r_pq[63:32]) : 32'sd0;
        c_omax = r_pvq ? $signed(r_pq[31:0]) : 32'sh80000000;
        c_z    = r_sq;
        c_d    = 33'(r_m) - 33'(c_z);
        c_etab = (r_state == S_E2) ? exp_sixteenth(r_dl[7:4]) : exp_256th(r_dl[3:0]);
        c_emul = 35'(r_e) * 35'(c_etab) + 35'd32768;
        c_e    = r_big ? 17'd0 : r_e;
    end

    // Memory port control.
    always_comb begin
        c_wwe    = (r_state == S_IDLE) && i_valid && (i_mode == MODE_WEIGHT) &&
                   (32'(i_index) < WEIGHT_WORDS);
        c_wraddr = (r_state == S_BREAD) ? WAW'(r_bptr) : r_wptr;
        c_swe    = 1'b0;
        c_swaddr = SAW'(r_o);
        c_swdata = c_y;
        if (r_state == S_WB) begin
            case (r_layer)
                L_PHI1, L_HEAD1: c_swe = 1'b1;
                L_HEAD2: begin
                    c_swe    = 1'b1;
                    c_swaddr = SAW'(MAX_WIDTH) + SAW'(r_o);
                end
                L_OUT: begin
                    c_swe    = 1'b1;
                    c_swaddr = SAW'(2 * MAX_WIDTH) + SAW'(r_o);
                end
                default: c_swe = 1'b0;
            endcase
        end else if (r_state == S_EWR) begin
            c_swe    = 1'b1;
            c_swaddr = SAW'(2 * MAX_WIDTH) + SAW'(r_o);
            c_swdata = 32'($unsigned(c_e));
        end
        c_pwe       = (r_state == S_POOL);
        c_div_start = (r_state == S_DIVGO);
        c_div_num   = DIV_NW'({r_sq[16:0], 16'h0000}) + DIV_NW'(r_tot >> 1);
    end

    always_ff @(posedge i_clk) begin
        if (c_wwe) begin
            r_wmem[WAW'(i_index)] <= i_value;
        end
        r_wq <= r_wmem[c_wraddr];
    end

    always_ff @(posedge i_clk) begin
        if (c_swe) begin
            r_smem[c_swaddr] <= c_swdata;
        end
        r_sq <= r_smem[c_sraddr];
    end

    always_ff @(posedge i_clk) begin
        if (c_pwe) begin
            r_pmem[PAW'(r_o)] <= {sat32(38'(c_osum) + 38'(r_y)),
                                  (r_y > c_omax) ? r_y : c_omax};
        end
        r_pq  <= r_pmem[c_praddr];
        r_pvq <= r_pvld[c_praddr];
    end

    spms_div #(
        .NW (DIV_NW),
        .DW (TW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (c_div_start),
        .i_num   (c_div_num),
        .i_den   (r_tot),
        .o_done  (c_div_done),
        .o_quot  (c_div_q)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_mode == MODE_STONE && 32'(i_index) == STONE_FEATURES - 1) begin
                        n_state = S_SETUP;
                    end else if (i_mode == MODE_GLOBAL &&
                                 32'(i_index) == GLOBAL_FEATURES - 1) begin
                        n_state = S_SETUP;
                    end
                end
            end
            S_SETUP: n_state = S_BMOD;
            S_BMOD: begin
                if (r_bptr < BW'(WEIGHT_WORDS)) begin
                    n_state = c_comp ? S_BREAD : S_SETUP;
                end
            end
            S_BREAD: n_state = S_BIAS;
            S_BIAS:  n_state = S_MAC;
            S_MAC: begin
                if (c_mac_done) n_state = S_WB;
            end
            S_WB: begin
                if (r_layer == L_PHI2) begin
                    n_state = S_POOL;
                end else if (!c_row_last) begin
                    n_state = S_BREAD;
                end else begin
                    n_state = (r_layer == L_OUT) ? S_MAXRD : S_SETUP;
                end
            end
            S_POOL:    n_state = c_row_last ? S_IDLE : S_BREAD;
            S_MAXRD:   n_state = S_MAX;
            S_MAX:     n_state = c_klast ? S_EXRD : S_MAXRD;
            S_EXRD:    n_state = S_E1;
            S_E1:      n_state = S_E2;
            S_E2:      n_state = S_E3;
            S_E3:      n_state = S_EWR;
            S_EWR:     n_state = c_klast ? S_DIVRD : S_EXRD;
            S_DIVRD:   n_state = S_DIVGO;
            S_DIVGO:   n_state = S_DIVWAIT;
            S_DIVWAIT: begin
                if (c_div_done) n_state = S_OUT;
            end
            S_OUT: begin
                if (i_ready) n_state = c_klast ? S_IDLE : S_DIVRD;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Handshake outputs.
    always_comb begin
        o_ready       = (r_state == S_IDLE);
        o_valid       = (r_state == S_OUT);
        o_cfg_ready   = 1'b1;
        o_class_index = r_ocls;
        o_probability = r_oprob;
        o_last_class  = r_olast;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_layer <= L_PHI1;
            r_head  <= 1'b0;
            r_seen  <= 1'b0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_pvld  <= '0;
            r_sh    <= CFG_DW'(CFG_RESET);
            r_pw    <= CFG_DW'(CFG_RESET);
            r_hh    <= CFG_DW'(CFG_RESET);
            r_hs    <= CFG_DW'(CFG_RESET);
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_STONE_HIDDEN: r_sh <= i_cfg_data;
                    CFG_POOL:         r_pw <= i_cfg_data;
                    CFG_HEAD_HIDDEN:  r_hh <= i_cfg_data;
                    CFG_HEAD_SECOND:  r_hs <= i_cfg_data;
                    default:          r_sh <= r_sh;
                endcase
            end

            // MAC pipe: operand fetch, product, accumulate.
            r_v1 <= c_issue;
            r_v2 <= r_v1;
            if (r_v1) begin
                r_prod <= r_wq * c_x;
            end
            if (r_v2) begin
                r_acc <= sat32(38'(r_acc) + 38'(r_prod >>> 12));
            end

            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        if (i_mode == MODE_STONE && 32'(i_index) < STONE_FEATURES) begin
                            r_sbuf[SIW'(i_index)] <= i_value;
                        end
                        if (i_mode == MODE_GLOBAL && 32'(i_index) < GLOBAL_FEATURES) begin
                            r_gbuf[GIW'(i_index)] <= i_value;
                        end
                        r_layer <= L_PHI1;
                        r_base  <= '0;
                        r_head  <= (i_mode == MODE_GLOBAL);
                    end
                end
                S_SETUP: r_bptr <= BW'(r_base) + BW'(c_nout) * BW'(c_nin);
                S_BMOD: begin
                    if (r_bptr >= BW'(WEIGHT_WORDS)) begin
                        r_bptr <= r_bptr - BW'(WEIGHT_WORDS);
                    end else if (c_comp) begin
                        r_wptr <= r_base;
                        r_o    <= '0;
                    end else begin
                        r_base  <= c_bend;
                        r_layer <= c_next_layer;
                    end
                end
                S_BIAS: begin
                    r_acc <= 32'(r_wq);
                    r_i   <= '0;
                end
                S_MAC: begin
                    if (c_issue) begin
                        r_i    <= r_i + IW'(1);
                        r_wptr <= c_winc;
                        r_xsel <= c_xsel;
                        r_xreg <= c_xreg;
                    end
                end
                S_WB: r_y <= c_y;
                S_POOL: r_pvld[PAW'(r_o)] <= 1'b1;
                S_MAX: begin
                    if (r_o == '0 || c_z > r_m) r_m <= c_z;
                    r_o <= c_klast ? '0 : r_o + OW'(1);
                    if (c_klast) r_tot <= '0;
                end
                S_E1: begin
                    r_big <= |c_d[32:16];
                    r_dl  <= c_d[11:4];
                    r_e   <= exp_int(c_d[15:12]);
                end
                S_E2, S_E3: r_e <= c_emul[32:16];
                S_EWR: begin
                    r_tot <= r_tot + TW'(c_e);
                    r_o   <= c_klast ? '0 : r_o + OW'(1);
                end
                S_DIVWAIT: begin
                    if (c_div_done) begin
                        r_oprob <= (|c_div_q[DIV_NW-1:16]) ? 16'hFFFF : c_div_q[15:0];
                        r_ocls  <= 6'(r_o);
                        r_olast <= c_klast;
                    end
                end
                S_OUT: begin
                    if (i_ready) begin
                        if (c_klast) begin
                            r_pvld <= '0;
                            r_seen <= 1'b0;
                        end else begin
                            r_o <= r_o + OW'(1);
                        end
                    end
                end
                default: r_head <= r_head;
            endcase

            // Row finished: step to the next bias, or close out the layer.
            if (c_adv) begin
                r_o    <= (c_row_last && r_layer == L_OUT) ? '0 : r_o + OW'(1);
                r_bptr <= c_binc;
                if (c_row_last) begin
                    r_base  <= WAW'(c_binc);
                    r_layer <= c_next_layer;
                    if (r_layer == L_PHI2) r_seen <= 1'b1;
                end
            end
        end
    end

endmodule
